### hw/rtl/atfa_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// atfa_pkg
// Types and constants shared by the TX16 API frame assembler.
// ----------------------------------------------------------------------------
package atfa_pkg;

  localparam int unsigned MAX_PAYLOAD = 100;
  localparam int unsigned LEN_W       = 7;

  localparam logic [7:0] SOF_BYTE    = 8'h7E;
  localparam logic [7:0] LEN_HI_BYTE = 8'h00;
  localparam logic [7:0] LEN_OFFSET  = 8'd5;
  localparam logic [7:0] API_ID_TX16 = 8'h01;
  localparam logic [7:0] OPTIONS     = 8'h00;
  localparam logic [7:0] CHK_BASE    = 8'hFF;

  typedef struct packed {
    logic [7:0]       payload_byte;
    logic [LEN_W-1:0] payload_len;
    logic [15:0]      dest_address;
  } in_item_t;

  typedef struct packed {
    logic [7:0] frame_byte;
    logic       frame_last;
  } out_item_t;

  typedef struct packed {
    logic item_vld;
    logic out_rdy;
  } emit_req_t;

  typedef struct packed {
    logic fire;
    logic done;
  } emit_rsp_t;

  typedef enum logic [9:0] {
    S_SOF      = 10'b00_0000_0001,
    S_LEN_HI   = 10'b00_0000_0010,
    S_LEN_LO   = 10'b00_0000_0100,
    S_API_ID   = 10'b00_0000_1000,
    S_FRAME_ID = 10'b00_0001_0000,
    S_DEST_HI  = 10'b00_0010_0000,
    S_DEST_LO  = 10'b00_0100_0000,
    S_OPTIONS  = 10'b00_1000_0000,
    S_DATA     = 10'b01_0000_0000,
    S_CHECKSUM = 10'b10_0000_0000
  } slot_e;

endpackage

### hw/rtl/atfa_emitter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// atfa_emitter
// Frame state and byte sequencer: steps through header, data and checksum
// slots of the held transaction, one frame byte per cycle while not stalled.
// ----------------------------------------------------------------------------
module atfa_emitter #(
  parameter int unsigned MaxPayload = atfa_pkg::MAX_PAYLOAD
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  atfa_pkg::in_item_t  item_i,
  input  logic [7:0]          frame_id_i,
  input  atfa_pkg::emit_req_t req_i,
  output atfa_pkg::emit_rsp_t rsp_o,
  output atfa_pkg::out_item_t res_o
);
  import atfa_pkg::*;

  localparam int unsigned CntW = $clog2(MaxPayload + 1);
  localparam int unsigned CmpW = (CntW > LEN_W) ? CntW : LEN_W;

  slot_e           slot_q, slot_d, cur_slot;
  logic            mid_q, mid_d;
  logic [CntW-1:0] pos_q, pos_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [7:0]      sum_q, sum_d;

  logic [CmpW-1:0] len_ext;
  logic [CntW-1:0] len_clamped;
  logic [CntW:0]   pos_inc;
  logic            data_last;
  logic [7:0]      byte_val;
  logic            summed;
  logic            done;
  slot_e           nxt_slot;
  logic            fire;

  always_comb begin
    len_ext     = CmpW'(item_i.payload_len);
    len_clamped = (len_ext > CmpW'(MaxPayload)) ? CntW'(MaxPayload) : CntW'(len_ext);
    pos_inc     = {1'b0, pos_q} + (CntW+1)'(1);
    data_last   = pos_inc >= {1'b0, cnt_q};
    cur_slot    = mid_q ? slot_q : ((pos_q == '0) ? S_SOF : S_DATA);
  end

  always_comb begin
    byte_val = '0;
    summed   = 1'b0;
    done     = 1'b0;
    nxt_slot = cur_slot;
    unique case (cur_slot)
      S_SOF: begin
        byte_val = SOF_BYTE;
        nxt_slot = S_LEN_HI;
      end
      S_LEN_HI: begin
        byte_val = LEN_HI_BYTE;
        nxt_slot = S_LEN_LO;
      end
      S_LEN_LO: begin
        byte_val = 8'(cnt_q) + LEN_OFFSET;
        nxt_slot = S_API_ID;
      end
      S_API_ID: begin
        byte_val = API_ID_TX16;
        summed   = 1'b1;
        nxt_slot = S_FRAME_ID;
      end
      S_FRAME_ID: begin
        byte_val = frame_id_i;
        summed   = 1'b1;
        nxt_slot = S_DEST_HI;
      end
      S_DEST_HI: begin
        byte_val = item_i.dest_address[15:8];
        summed   = 1'b1;
        nxt_slot = S_DEST_LO;
      end
      S_DEST_LO: begin
        byte_val = item_i.dest_address[7:0];
        summed   = 1'b1;
        nxt_slot = S_OPTIONS;
      end
      S_OPTIONS: begin
        byte_val = OPTIONS;
        summed   = 1'b1;
        nxt_slot = (cnt_q == '0) ? S_CHECKSUM : S_DATA;
      end
      S_DATA: begin
        byte_val = item_i.payload_byte;
        summed   = 1'b1;
        nxt_slot = S_CHECKSUM;
        done     = !data_last;
      end
      S_CHECKSUM: begin
        byte_val = CHK_BASE - sum_q;
        done     = 1'b1;
      end
      default: begin
        done = 1'b1;
      end
    endcase
  end

  assign fire = req_i.item_vld && req_i.out_rdy;

  always_comb begin
    slot_d = slot_q;
    mid_d  = mid_q;
    pos_d  = pos_q;
    cnt_d  = cnt_q;
    sum_d  = sum_q;
    if (fire) begin
      slot_d = nxt_slot;
      mid_d  = !done;
      if (summed) begin
        sum_d = sum_q + byte_val;
      end
      unique case (cur_slot)
        S_SOF: begin
          cnt_d = len_clamped;
          sum_d = '0;
        end
        S_DATA: begin
          pos_d = pos_inc[CntW-1:0];
        end
        S_CHECKSUM: begin
          pos_d = '0;
          sum_d = '0;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q <= S_SOF;
      mid_q  <= 1'b0;
      pos_q  <= '0;
      cnt_q  <= '0;
      sum_q  <= '0;
    end else begin
      slot_q <= slot_d;
      mid_q  <= mid_d;
      pos_q  <= pos_d;
      cnt_q  <= cnt_d;
      sum_q  <= sum_d;
    end
  end

  assign rsp_o.fire       = fire;
  assign rsp_o.done       = done;
  assign res_o.frame_byte = byte_val;
  assign res_o.frame_last = (cur_slot == S_CHECKSUM);

endmodule

### hw/rtl/api_tx_frame_assembler.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// api_tx_frame_assembler
// Wraps streamed payload bytes into TX16 API frames with header and checksum.
// ----------------------------------------------------------------------------
// One input transaction is held in an input register while the sequencer
// emits its frame bytes, one per cycle unless the output stalls, into an
// output register. A new transaction is taken in the same cycle as the last
// byte of the held one, so payload streams at one byte per clock unless the
// output stalls; the first byte of a frame follows eight header bytes, the
// last byte is followed by the checksum, and a zero-length frame is the header
// and checksum alone. frame_id is sampled when the header is sent; the user is
// to write it only while the block is idle, which the block does not enforce.
module api_tx_frame_assembler #(
  parameter int unsigned MaxPayload = atfa_pkg::MAX_PAYLOAD
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [7:0]          cfg_wdata_i,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  atfa_pkg::in_item_t  in_item_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output atfa_pkg::out_item_t out_item_o
);
  import atfa_pkg::*;

  logic [7:0] frame_id_q;
  in_item_t   item_q;
  logic       item_vld_q;
  out_item_t  out_q;
  logic       out_vld_q;

  emit_req_t  req;
  emit_rsp_t  rsp;
  out_item_t  res;
  logic       out_rdy;
  logic       in_acc;

  assign out_rdy      = !out_vld_q || !out_stall_i;
  assign req.item_vld = item_vld_q;
  assign req.out_rdy  = out_rdy;
  assign in_stall_o   = item_vld_q && !(rsp.fire && rsp.done);
  assign in_acc       = in_valid_i && !in_stall_o;

  atfa_emitter #(
    .MaxPayload(MaxPayload)
  ) u_emitter (
    .clk_i,
    .rst_ni,
    .item_i    (item_q),
    .frame_id_i(frame_id_q),
    .req_i     (req),
    .rsp_o     (rsp),
    .res_o     (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_id_q <= '0;
      item_vld_q <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        frame_id_q <= cfg_wdata_i;
      end
      if (in_acc) begin
        item_vld_q <= 1'b1;
      end else if (rsp.fire && rsp.done) begin
        item_vld_q <= 1'b0;
      end
      if (rsp.fire) begin
        out_vld_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      item_q <= in_item_i;
    end
    if (rsp.fire) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_item_o  = out_q;

endmodule
